// File: design/packet_magic_number_detect_defines.svh
// Assertion macros for the packet magic number detector.
// Included by the modules that carry concurrent checks; no other dependencies.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef PACKET_MAGIC_NUMBER_DETECT_DEFINES_SVH
`define PACKET_MAGIC_NUMBER_DETECT_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define PMND_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pmnd check failed");

`define PMND_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pmnd check failed");

`else

`define PMND_ASSERT_SAME(label, clk, rst_n, ante, cons)

`define PMND_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: design/pmnd_pkg.sv
// Shared types, signature table and kind codes for the magic number detector.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pmnd_pkg;

    localparam int ByteW    = 8;
    localparam int KindW    = 4;
    localparam int KindCount = 11;
    localparam int SigCount = 13;

    localparam logic [KindW-1:0] KIND_NONE   = 4'd0;
    localparam logic [KindW-1:0] KIND_GIF    = 4'd1;
    localparam logic [KindW-1:0] KIND_JPEG   = 4'd2;
    localparam logic [KindW-1:0] KIND_PNG    = 4'd3;
    localparam logic [KindW-1:0] KIND_PDF    = 4'd4;
    localparam logic [KindW-1:0] KIND_ZIP    = 4'd5;
    localparam logic [KindW-1:0] KIND_BMP    = 4'd6;
    localparam logic [KindW-1:0] KIND_OFFICE = 4'd7;
    localparam logic [KindW-1:0] KIND_CLASS  = 4'd8;
    localparam logic [KindW-1:0] KIND_ELF    = 4'd9;
    localparam logic [KindW-1:0] KIND_TIFF   = 4'd10;
    localparam logic [KindW-1:0] KIND_MPEG   = 4'd11;

    localparam logic [15:0] BMP_SIG = 16'h424D;

    localparam logic [31:0] SigWord [SigCount] = '{
        32'h47494638, 32'hFFD8FFE0, 32'hFFD8FFDB, 32'h89504E47, 32'h25504446,
        32'h504B0304, 32'hD0CF11E0, 32'hCAFEBABE, 32'h7F454C46, 32'h49492A00,
        32'h4D4D002A, 32'h000001BA, 32'h000001B3
    };

    localparam logic [KindW-1:0] SigKind [SigCount] = '{
        KIND_GIF, KIND_JPEG, KIND_JPEG, KIND_PNG, KIND_PDF,
        KIND_ZIP, KIND_OFFICE, KIND_CLASS, KIND_ELF, KIND_TIFF,
        KIND_TIFF, KIND_MPEG, KIND_MPEG
    };

    typedef struct packed {
        logic             valid;
        logic [ByteW-1:0] data_byte;
        logic             end_of_packet;
    } beat_t;

    typedef logic [KindCount-1:0] kind_mask_t;

    // lowest set kind wins
    function automatic logic [KindW-1:0] first_kind(input kind_mask_t found);
        logic [KindW-1:0] k;
        k = KIND_NONE;
        for (int i = KindCount - 1; i >= 0; i--)
        begin
            if (found[i])
            begin
                k = KindW'(i + 1);
            end
        end
        return k;
    endfunction

endpackage

`default_nettype wire

// File: design/pmnd_pkt_if.sv
// Input channel: one packet byte per beat with an end-of-packet flag.
// Depends on pmnd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface pmnd_pkt_if;
    logic                       valid;
    logic                       ready;
    logic [pmnd_pkg::ByteW-1:0] data_byte;
    logic                       end_of_packet;

    modport source (output valid, output data_byte, output end_of_packet, input ready);
    modport sink   (input valid, input data_byte, input end_of_packet, output ready);
endinterface

`default_nettype wire

// File: design/pmnd_res_if.sv
// Result channel: one file kind per packet.
// Depends on pmnd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface pmnd_res_if;
    logic                       valid;
    logic                       ready;
    logic [pmnd_pkg::KindW-1:0] file_kind;

    modport source (output valid, output file_kind, input ready);
    modport sink   (input valid, input file_kind, output ready);
endinterface

`default_nettype wire

// File: design/pmnd_sig_match.sv
// Window compare against the fixed signature table.
// Depends on pmnd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pmnd_sig_match (
    input  wire logic [23:0]                recent,
    input  wire logic [1:0]                 seen,
    input  wire logic [pmnd_pkg::ByteW-1:0] data_byte,
    output pmnd_pkg::kind_mask_t            hits
);

    logic [31:0] window;
    logic        full_window;
    logic        bmp_window;

    assign window      = {recent, data_byte};
    assign full_window = (seen == 2'd3);
    assign bmp_window  = (seen != 2'd0);

    always_comb
    begin
        hits = '0;
        for (int i = 0; i < pmnd_pkg::SigCount; i++)
        begin
            if (full_window && window == pmnd_pkg::SigWord[i])
            begin
                hits[pmnd_pkg::SigKind[i] - 4'd1] = 1'b1;
            end
        end
        if (bmp_window && window[15:0] == pmnd_pkg::BMP_SIG)
        begin
            hits[pmnd_pkg::KIND_BMP - 4'd1] = 1'b1;
        end
    end

endmodule

`default_nettype wire

// File: design/pmnd_in_reg.sv
// Input register stage for packet bytes.
// Depends on pmnd_pkg and pmnd_pkt_if.
`timescale 1ns / 1ps
`default_nettype none

module pmnd_in_reg (
    input  wire logic     clk,
    input  wire logic     rst_n,
    pmnd_pkt_if.sink      pkt,
    input  wire logic     take,
    output pmnd_pkg::beat_t beat
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [pmnd_pkg::ByteW-1:0] byte_reg;
    logic                       eop_reg;
    logic                       load;

    assign pkt.ready  = !valid_reg || take;
    assign load       = pkt.valid && pkt.ready;
    assign valid_next = load || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= pkt.data_byte;
            eop_reg  <= pkt.end_of_packet;
        end
    end

    assign beat.valid         = valid_reg;
    assign beat.data_byte     = byte_reg;
    assign beat.end_of_packet = eop_reg;

endmodule

`default_nettype wire

// File: design/pmnd_tracker.sv
// Per-packet byte history, found flags and result register.
// Depends on pmnd_pkg, pmnd_res_if, pmnd_sig_match and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "packet_magic_number_detect_defines.svh"

module pmnd_tracker (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  pmnd_pkg::beat_t beat,
    output logic           take,
    pmnd_res_if.source     res
);

    logic [23:0]                recent_reg;
    logic [23:0]                recent_next;
    logic [1:0]                 seen_reg;
    logic [1:0]                 seen_next;
    pmnd_pkg::kind_mask_t       found_reg;
    pmnd_pkg::kind_mask_t       found_next;
    pmnd_pkg::kind_mask_t       hits;
    pmnd_pkg::kind_mask_t       found_all;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [pmnd_pkg::KindW-1:0] kind_reg;
    logic                       out_free;
    logic                       finish;

    pmnd_sig_match u_match (
        .recent    (recent_reg),
        .seen      (seen_reg),
        .data_byte (beat.data_byte),
        .hits      (hits)
    );

    assign out_free  = !out_valid_reg || res.ready;
    assign take      = beat.valid && (!beat.end_of_packet || out_free);
    assign finish    = take && beat.end_of_packet;
    assign found_all = found_reg | hits;

    always_comb
    begin
        recent_next = recent_reg;
        seen_next   = seen_reg;
        found_next  = found_reg;
        if (finish)
        begin
            recent_next = '0;
            seen_next   = '0;
            found_next  = '0;
        end
        else if (take)
        begin
            recent_next = {recent_reg[15:0], beat.data_byte};
            seen_next   = (seen_reg == 2'd3) ? seen_reg : seen_reg + 2'd1;
            found_next  = found_all;
        end
    end

    assign out_valid_next = finish || (out_valid_reg && !res.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recent_reg    <= '0;
            seen_reg      <= '0;
            found_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            recent_reg    <= recent_next;
            seen_reg      <= seen_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            kind_reg <= pmnd_pkg::first_kind(found_all);
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.file_kind = kind_reg;

    `PMND_ASSERT_SAME(a_kind_range, clk, rst_n, out_valid_reg,
        kind_reg <= pmnd_pkg::KIND_MPEG)
    `PMND_ASSERT_NEXT(a_clear_after_eop, clk, rst_n, finish,
        seen_reg == 2'd0 && found_reg == '0 && recent_reg == '0)
    `PMND_ASSERT_NEXT(a_seen_count, clk, rst_n, take && !finish && seen_reg != 2'd3,
        seen_reg == $past(seen_reg) + 2'd1)
    `PMND_ASSERT_NEXT(a_no_spurious_result, clk, rst_n, !out_valid_reg && !finish,
        !out_valid_reg)
    `PMND_ASSERT_SAME(a_eop_waits_on_full, clk, rst_n,
        beat.valid && beat.end_of_packet && out_valid_reg && !res.ready, !take)

endmodule

`default_nettype wire

// File: design/packet_magic_number_detect.sv
// Packet magic number detector: one byte per beat, one file kind per packet.
// The result for a packet is registered: its last byte passes the input register, then the tracker loads the result.
// Throughput: one byte per cycle unless stalled; the next packet streams on while a result waits.
// A held result stalls input only when the next last byte reaches the input register.
// Reset (rst_n low, asynchronous) clears history, found flags and both valid flags.
`timescale 1ns / 1ps
`default_nettype none

module packet_magic_number_detect (
    input  wire logic  clk,
    input  wire logic  rst_n,
    pmnd_pkt_if.sink   pkt,
    pmnd_res_if.source res
);

    pmnd_pkg::beat_t beat;
    logic            take;

    pmnd_in_reg u_in_reg (
        .clk   (clk),
        .rst_n (rst_n),
        .pkt   (pkt),
        .take  (take),
        .beat  (beat)
    );

    pmnd_tracker u_tracker (
        .clk   (clk),
        .rst_n (rst_n),
        .beat  (beat),
        .take  (take),
        .res   (res)
    );

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// Testbench for packet_magic_number_detect: directed and random packets, byte by byte,
// checked against a signature scanner kept in the bench; random idling on both channels.
// Depends on pmnd_pkg, pmnd_pkt_if, pmnd_res_if and the detector RTL.
`timescale 1ns / 1ps

module tb;
    import pmnd_pkg::*;

    localparam int SIG_TOTAL  = 14;
    localparam int IDLE_LIMIT = 400;
    localparam int RAND_BEATS = 1500;

    localparam logic [31:0] SIG_WORD [SIG_TOTAL] = '{
        32'h47494638, 32'hFFD8FFE0, 32'hFFD8FFDB, 32'h89504E47, 32'h25504446,
        32'h504B0304, 32'h0000424D, 32'hD0CF11E0, 32'hCAFEBABE, 32'h7F454C46,
        32'h49492A00, 32'h4D4D002A, 32'h000001BA, 32'h000001B3
    };
    localparam int SIG_LEN [SIG_TOTAL] = '{4, 4, 4, 4, 4, 4, 2, 4, 4, 4, 4, 4, 4, 4};
    localparam logic [KindW-1:0] SIG_KIND [SIG_TOTAL] = '{
        KIND_GIF, KIND_JPEG, KIND_JPEG, KIND_PNG, KIND_PDF,
        KIND_ZIP, KIND_BMP, KIND_OFFICE, KIND_CLASS, KIND_ELF,
        KIND_TIFF, KIND_TIFF, KIND_MPEG, KIND_MPEG
    };

    typedef struct {
        logic [ByteW-1:0] data;
        logic             eop;
        int unsigned      gap;
    } pkt_beat_t;

    logic clk;
    logic rst_n;

    pmnd_pkt_if pkt ();
    pmnd_res_if res ();

    packet_magic_number_detect i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pkt   (pkt),
        .res   (res)
    );

    pkt_beat_t        beats_to_send [$];
    logic [KindW-1:0] kind_expected [$];

    // scanner state
    logic [23:0]      win_history;
    logic [1:0]       hist_count;
    kind_mask_t       kinds_hit;

    logic             src_calm;
    logic             snk_calm;
    logic             beat_taken;
    logic             res_taken;
    int unsigned      gap_count;
    int unsigned      stall_left;
    int unsigned      idle_cycles;
    int               errors;
    int               beats_done;
    int               beats_total;
    int               packets_total;
    int               results_done;
    int               kind_count [16];

    function automatic logic [ByteW-1:0] sig_byte(input int idx, input int pos);
        return SIG_WORD[idx][8*(SIG_LEN[idx]-1-pos) +: 8];
    endfunction

    function automatic void scan_byte(input logic [ByteW-1:0] b, input logic eop);
        logic [31:0]      window;
        logic [KindW-1:0] kind;
        window = {win_history, b};
        for (int i = 0; i < SIG_TOTAL; i++)
        begin
            if (SIG_LEN[i] == 4 && hist_count == 2'd3 && window == SIG_WORD[i])
            begin
                kinds_hit[SIG_KIND[i] - 1] = 1'b1;
            end
            if (SIG_LEN[i] == 2 && hist_count != 2'd0 && window[15:0] == SIG_WORD[i][15:0])
            begin
                kinds_hit[SIG_KIND[i] - 1] = 1'b1;
            end
        end
        if (eop)
        begin
            kind = KIND_NONE;
            for (int k = KindCount; k >= 1; k--)
            begin
                if (kinds_hit[k-1])
                begin
                    kind = KindW'(k);
                end
            end
            kind_expected.push_back(kind);
            win_history = '0;
            hist_count  = '0;
            kinds_hit   = '0;
        end
        else
        begin
            win_history = window[23:0];
            if (hist_count != 2'd3)
            begin
                hist_count = hist_count + 2'd1;
            end
        end
    endfunction

    task automatic push_beat(input logic [ByteW-1:0] b, input logic eop);
        pkt_beat_t beat;
        beat.data = b;
        beat.eop  = eop;
        beat.gap  = src_calm ? 0 : $urandom_range(0, 13);
        beats_to_send.push_back(beat);
        if (eop)
        begin
            packets_total++;
        end
    endtask

    task automatic push_word(input logic [31:0] w, input int len, input logic eop);
        for (int j = 0; j < len; j++)
        begin
            push_beat(w[8*(len-1-j) +: 8], eop && j == len - 1);
        end
    endtask

    // random packet: noise, whole signatures, broken heads and tails, single signature bytes
    task automatic push_random_packet();
        logic [ByteW-1:0] body [$];
        int               target;
        int               idx;
        int               len;
        int               cut;
        target = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        while (body.size() < target)
        begin
            idx = $urandom_range(0, SIG_TOTAL - 1);
            len = SIG_LEN[idx];
            cut = $urandom_range(1, len - 1);
            case ($urandom_range(0, 5))
                0, 5:
                begin
                    body.push_back(8'($urandom));
                end
                1:
                begin
                    for (int j = 0; j < len; j++)
                    begin
                        body.push_back(sig_byte(idx, j));
                    end
                end
                2:
                begin
                    for (int j = 0; j < cut; j++)
                    begin
                        body.push_back(sig_byte(idx, j));
                    end
                end
                3:
                begin
                    for (int j = cut; j < len; j++)
                    begin
                        body.push_back(sig_byte(idx, j));
                    end
                end
                default:
                begin
                    body.push_back(sig_byte(idx, $urandom_range(0, len - 1)));
                end
            endcase
        end
        if ($urandom_range(0, 7) == 0)
        begin
            src_calm = !src_calm;
        end
        for (int j = 0; j < body.size(); j++)
        begin
            push_beat(body[j], j == body.size() - 1);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // driver
    always @(negedge clk)
    begin
        logic next_valid;
        next_valid = pkt.valid && !beat_taken;
        if (rst_n && !next_valid && beats_to_send.size() > 0)
        begin
            if (gap_count < beats_to_send[0].gap)
            begin
                gap_count++;
            end
            else
            begin
                pkt.data_byte     <= beats_to_send[0].data;
                pkt.end_of_packet <= beats_to_send[0].eop;
                beats_to_send.delete(0);
                gap_count  = 0;
                next_valid = 1'b1;
            end
        end
        pkt.valid <= next_valid;
    end

    // result sink: each result is held off by a randomly drawn stall
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (res_taken)
            begin
                if ($urandom_range(0, 15) == 0)
                begin
                    snk_calm = !snk_calm;
                end
                stall_left = snk_calm ? 0 : $urandom_range(0, 13);
            end
            if (res.valid && stall_left > 0)
            begin
                res.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                res.ready <= (stall_left == 0);
            end
        end
    end

    // monitor, scoreboard and watchdog
    always @(posedge clk)
    begin
        logic [KindW-1:0] want;
        beat_taken <= pkt.valid && pkt.ready;
        res_taken  <= res.valid && res.ready;
        if (rst_n)
        begin
            if (pkt.valid && pkt.ready)
            begin
                scan_byte(pkt.data_byte, pkt.end_of_packet);
                beats_done++;
            end
            if (res.valid && res.ready)
            begin
                results_done++;
                if (kind_expected.size() == 0)
                begin
                    $error("file_kind: no result expected, actual %0d", res.file_kind);
                    errors++;
                end
                else
                begin
                    want = kind_expected.pop_front();
                    kind_count[want]++;
                    if (res.file_kind !== want)
                    begin
                        $error("file_kind: expected %0d, actual %0d", want, res.file_kind);
                        errors++;
                    end
                end
            end
            if ((pkt.valid && pkt.ready) || (res.valid && res.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT)
                begin
                    $display("stalled for %0d cycles", idle_cycles);
                    $display("FAILURE");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        string hits;
        rst_n             = 1'b0;
        pkt.valid         = 1'b0;
        pkt.data_byte     = '0;
        pkt.end_of_packet = 1'b0;
        res.ready         = 1'b0;
        beat_taken        = 1'b0;
        res_taken         = 1'b0;
        src_calm          = 1'b0;
        snk_calm          = 1'b0;
        gap_count         = 0;
        stall_left        = 0;
        idle_cycles       = 0;
        errors            = 0;
        beats_done        = 0;
        packets_total     = 0;
        results_done      = 0;
        win_history       = '0;
        hist_count        = '0;
        kinds_hit         = '0;
        foreach (kind_count[k])
        begin
            kind_count[k] = 0;
        end

        // directed: extreme single bytes, shortest signature, split signatures,
        // priority between kinds, alternate JPEG/MPEG/TIFF words
        push_word(32'h00, 1, 1'b1);
        push_word(32'hFF, 1, 1'b1);
        push_word(32'h424D, 2, 1'b1);
        push_word(32'h42, 1, 1'b1);
        push_word(32'h4D, 1, 1'b1);
        push_word(32'hCAFEBABE, 4, 1'b0);
        push_word(32'h424D, 2, 1'b1);
        push_word(32'h474946, 3, 1'b1);
        push_word(32'h38, 1, 1'b1);
        push_word(32'hFFD8FFDB, 4, 1'b1);
        push_word(32'h000001B3, 4, 1'b1);
        push_word(32'h4D4D002A, 4, 1'b1);

        while (beats_to_send.size() < RAND_BEATS + 28)
        begin
            push_random_packet();
        end
        beats_total = beats_to_send.size();

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        while (!(beats_done == beats_total && kind_expected.size() == 0))
        begin
            @(negedge clk);
        end
        repeat (10) @(negedge clk);

        hits = "";
        for (int k = 0; k <= KindCount; k++)
        begin
            hits = {hits, $sformatf(" %0d:%0d", k, kind_count[k])};
        end
        $display("%0d packets, %0d bytes, %0d results checked, %0d errors",
                 packets_total, beats_done, results_done, errors);
        $display("results per file kind:%s", hits);
        if (errors == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
